// ===== hw/rtl/quintic_trajectory_pd_joint_control_top_defines.svh =====
// ----------------------------------------------------------------------------
// quintic_trajectory_pd_joint_control_top_defines.svh
// Assertion macros shared by the checker of the joint controller.
// ----------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_PD_JOINT_CONTROL_TOP_DEFINES_SVH
`define QUINTIC_TRAJECTORY_PD_JOINT_CONTROL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored during reset.
`define QTPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored during reset.
`define QTPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// qtpd_pkg
// Types, widths and codes of the quintic trajectory PD joint controller.
// ----------------------------------------------------------------------------
package qtpd_pkg;

  localparam int NUM_JOINTS    = 7;
  localparam int JOINT_W       = 3;
  localparam int POS_W         = 20;   // Q3.16
  localparam int GAIN_W        = 16;   // Q10.6
  localparam int PERIOD_W      = 16;
  localparam int DUR_W         = 26;
  localparam int TORQUE_W      = 32;
  localparam int T_W           = 24;   // Q0.24 normalized time
  localparam int S_W           = 30;   // position profile, Q.24
  localparam int V_W           = 32;   // velocity profile, Q.24
  localparam int DELTA_W       = POS_W + 1;
  localparam int QD_W          = POS_W + 3;
  localparam int W_W           = 32;
  localparam int MUL_W         = 34;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DIV_N         = 52;   // dividend bits, one per divider step
  localparam int DIV_CNT_W     = $clog2(DIV_N);
  localparam int DIFF_W        = 41;   // clamped damping error
  localparam int DIFF_SPLIT    = 20;   // low partial product width
  localparam int ACC_W         = 60;
  localparam int TORQUE_SHIFT  = 6;
  localparam int TICKS_PER_SEC = 1000000;
  localparam int DUR_RESET     = 5000000;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_CONTROL = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [JOINT_W-1:0]        joint;
    logic [PERIOD_W-1:0]       period_ticks;
    logic signed [POS_W-1:0]   position;
    logic signed [POS_W-1:0]   velocity;
    logic signed [POS_W-1:0]   target;
    logic [GAIN_W-1:0]         stiffness;
    logic [GAIN_W-1:0]         damping;
  } item_t;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque;
    logic [JOINT_W-1:0]         joint_out;
    logic                       torque_valid;
  } result_t;

  // Datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EXEC,
    OP_FINISH,
    OP_TDIV_START,
    OP_T_STORE,
    OP_MUL_TT,
    OP_ST_T2,
    OP_MUL_T2T,
    OP_ST_T3,
    OP_MUL_T3T,
    OP_ST_T4,
    OP_MUL_T4T,
    OP_ST_T5,
    OP_POLY,
    OP_MUL_SD,
    OP_ST_QD,
    OP_MUL_VD,
    OP_ST_W,
    OP_MUL_WK,
    OP_VDIV_START,
    OP_ST_DQD,
    OP_DQD_ZERO,
    OP_MUL_KP,
    OP_ACC_KP,
    OP_MUL_KDL,
    OP_ACC_KDL,
    OP_MUL_KDH,
    OP_ACC_KDH,
    OP_RESULT,
    OP_RESULT_ZERO
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_FIN,
    S_TDIV,
    S_TDIV_WAIT,
    S_T_STORE,
    S_MUL_TT,
    S_ST_T2,
    S_MUL_T2T,
    S_ST_T3,
    S_MUL_T3T,
    S_ST_T4,
    S_MUL_T4T,
    S_ST_T5,
    S_POLY,
    S_MUL_SD,
    S_ST_QD,
    S_MUL_VD,
    S_ST_W,
    S_MUL_WK,
    S_VDIV,
    S_VDIV_WAIT,
    S_ST_DQD,
    S_DQD_ZERO,
    S_MUL_KP,
    S_ACC_KP,
    S_MUL_KDL,
    S_ACC_KDL,
    S_MUL_KDH,
    S_ACC_KDH,
    S_RESULT,
    S_RESULT_ZERO
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ctl_ok;     // control beat on an existing joint
    logic finished;   // elapsed has reached the duration
    logic v_zero;     // velocity profile is zero
    logic div_done;   // divider finished this cycle
    logic out_free;   // result register can take a beat
  } dp_status_t;

endpackage

// ===== hw/rtl/quintic_trajectory_pd_joint_control_top.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_pd_joint_control_top
// Per-joint PD torque controller on a quintic minimum-jerk trajectory.
// ----------------------------------------------------------------------------
// One beat is processed at a time. During the motion a control beat uses
// the shared restoring divider for two 52-step passes (normalized time,
// then velocity scaling by the duration, skipped at zero velocity) and up
// to ten steps on the one multiplier; once the motion has finished, no
// divider pass runs. A stalled result holds the sequencer only at its last
// step. A finished result waits in the output register while the next beat
// is taken in. The user must write duration through cfg_write/cfg_data only
// while idle; the block itself does not enforce this.
module quintic_trajectory_pd_joint_control_top import qtpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_write,
  input  logic [DUR_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       idle;

  qtpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .cmd        (cmd),
    .idle       (idle)
  );

  qtpd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign item_stall = !idle;

endmodule

// ===== hw/rtl/qtpd_div.sv =====
// ----------------------------------------------------------------------------
// qtpd_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module qtpd_div import qtpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_N-1:0]     dividend,
  input  logic [DUR_W-1:0]     divisor,
  output logic [DIV_N-1:0]     quotient,
  output logic                 done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DUR_W-1:0]     rem;
  logic [DIV_N-1:0]     quo;
  logic [DUR_W:0]       trial;
  logic                 fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[DIV_N-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DUR_W'(trial - {1'b0, divisor}) : DUR_W'(trial);
      quo <= {quo[DIV_N-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== hw/rtl/qtpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// qtpd_ctrl
// Sequencer: steps the datapath through one beat's computation.
// ----------------------------------------------------------------------------
module qtpd_ctrl import qtpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       idle
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op     = OP_EXEC;
        state_next = status.ctl_ok ? S_CHECK : S_RESULT_ZERO;
      end
      S_CHECK:     state_next = status.finished ? S_FIN : S_TDIV;
      S_FIN: begin
        cmd.op     = OP_FINISH;
        state_next = S_MUL_SD;
      end
      S_TDIV: begin
        cmd.op     = OP_TDIV_START;
        state_next = S_TDIV_WAIT;
      end
      S_TDIV_WAIT: if (status.div_done) state_next = S_T_STORE;
      S_T_STORE: begin
        cmd.op     = OP_T_STORE;
        state_next = S_MUL_TT;
      end
      // Powers of t on the shared multiplier
      S_MUL_TT:  begin cmd.op = OP_MUL_TT;  state_next = S_ST_T2;   end
      S_ST_T2:   begin cmd.op = OP_ST_T2;   state_next = S_MUL_T2T; end
      S_MUL_T2T: begin cmd.op = OP_MUL_T2T; state_next = S_ST_T3;   end
      S_ST_T3:   begin cmd.op = OP_ST_T3;   state_next = S_MUL_T3T; end
      S_MUL_T3T: begin cmd.op = OP_MUL_T3T; state_next = S_ST_T4;   end
      S_ST_T4:   begin cmd.op = OP_ST_T4;   state_next = S_MUL_T4T; end
      S_MUL_T4T: begin cmd.op = OP_MUL_T4T; state_next = S_ST_T5;   end
      S_ST_T5:   begin cmd.op = OP_ST_T5;   state_next = S_POLY;    end
      S_POLY:    begin cmd.op = OP_POLY;    state_next = S_MUL_SD;  end
      // Desired position
      S_MUL_SD:  begin cmd.op = OP_MUL_SD;  state_next = S_ST_QD;   end
      S_ST_QD: begin
        cmd.op     = OP_ST_QD;
        state_next = status.v_zero ? S_DQD_ZERO : S_MUL_VD;
      end
      // Desired velocity
      S_MUL_VD:  begin cmd.op = OP_MUL_VD;  state_next = S_ST_W;    end
      S_ST_W:    begin cmd.op = OP_ST_W;    state_next = S_MUL_WK;  end
      S_MUL_WK:  begin cmd.op = OP_MUL_WK;  state_next = S_VDIV;    end
      S_VDIV: begin
        cmd.op     = OP_VDIV_START;
        state_next = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: if (status.div_done) state_next = S_ST_DQD;
      S_ST_DQD:   begin cmd.op = OP_ST_DQD;   state_next = S_MUL_KP; end
      S_DQD_ZERO: begin cmd.op = OP_DQD_ZERO; state_next = S_MUL_KP; end
      // PD sum
      S_MUL_KP:  begin cmd.op = OP_MUL_KP;  state_next = S_ACC_KP;  end
      S_ACC_KP:  begin cmd.op = OP_ACC_KP;  state_next = S_MUL_KDL; end
      S_MUL_KDL: begin cmd.op = OP_MUL_KDL; state_next = S_ACC_KDL; end
      S_ACC_KDL: begin cmd.op = OP_ACC_KDL; state_next = S_MUL_KDH; end
      S_MUL_KDH: begin cmd.op = OP_MUL_KDH; state_next = S_ACC_KDH; end
      S_ACC_KDH: begin cmd.op = OP_ACC_KDH; state_next = S_RESULT;  end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      S_RESULT_ZERO: begin
        if (status.out_free) begin
          cmd.op     = OP_RESULT_ZERO;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

endmodule

// ===== hw/rtl/qtpd_datapath.sv =====
// ----------------------------------------------------------------------------
// qtpd_datapath
// Joint tables, elapsed time, shared multiplier, divider and result register.
// ----------------------------------------------------------------------------
module qtpd_datapath import qtpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status,
  input  item_t            item,
  input  logic             cfg_write,
  input  logic [DUR_W-1:0] cfg_data,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  // Held input beat
  item_t in_r;

  // Per-joint state
  logic signed [POS_W-1:0]  tgt_tbl   [NUM_JOINTS];
  logic signed [POS_W-1:0]  start_tbl [NUM_JOINTS];
  logic [GAIN_W-1:0]        kp_tbl    [NUM_JOINTS];
  logic [GAIN_W-1:0]        kd_tbl    [NUM_JOINTS];
  logic [DUR_W-1:0]         elapsed;
  logic [DUR_W-1:0]         duration;

  // Working registers
  logic [T_W-1:0]              t, t2, t3, t4, t5;
  logic signed [S_W-1:0]       s;
  logic signed [V_W-1:0]       v;
  logic signed [QD_W-1:0]      qd;
  logic signed [W_W-1:0]       w;
  logic                        vsign;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [ACC_W-1:0]     acc;
  logic signed [PROD_W-1:0]    p;

  logic                        ok;
  logic [JOINT_W-1:0]          jsel;
  logic signed [POS_W-1:0]     start_sel;
  logic signed [DELTA_W-1:0]   delta;
  logic [DUR_W:0]              e_sum;
  logic signed [MUL_W-1:0]     ma, mb;
  logic [S_W-1:0]              s_u;
  logic [V_W-1:0]              v_u;
  logic                        div_start;
  logic [DIV_N-1:0]            div_dvd, div_quo;
  logic                        div_done;
  logic signed [PROD_W-1:0]    p_abs;
  logic signed [DIV_N:0]       q_signed;
  logic signed [DIV_N-8:0]     dqd;
  logic signed [DIV_N-6:0]     dd_full;
  logic signed [ACC_W-1:0]     tq;
  logic signed [TORQUE_W-1:0]  tq_sat;

  // Table read for the held joint
  always_comb begin
    ok        = 32'(in_r.joint) < NUM_JOINTS;
    jsel      = ok ? in_r.joint : '0;
    start_sel = start_tbl[jsel];
    delta     = DELTA_W'(tgt_tbl[jsel]) - DELTA_W'(start_sel);
    e_sum     = {1'b0, elapsed} + (DUR_W+1)'(in_r.period_ticks);
  end

  // Profile polynomials, modulo arithmetic gives the signed sum
  always_comb begin
    s_u = S_W'(t5) * S_W'(6) - S_W'(t4) * S_W'(15) + S_W'(t3) * S_W'(10);
    v_u = V_W'(t4) * V_W'(30) - V_W'(t3) * V_W'(60) + V_W'(t2) * V_W'(30);
  end

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_TT:  begin ma = MUL_W'(t);  mb = MUL_W'(t); end
      OP_MUL_T2T: begin ma = MUL_W'(t2); mb = MUL_W'(t); end
      OP_MUL_T3T: begin ma = MUL_W'(t3); mb = MUL_W'(t); end
      OP_MUL_T4T: begin ma = MUL_W'(t4); mb = MUL_W'(t); end
      OP_MUL_SD:  begin ma = MUL_W'(s);  mb = MUL_W'(delta); end
      OP_MUL_VD:  begin ma = MUL_W'(v);  mb = MUL_W'(delta); end
      OP_MUL_WK:  begin ma = MUL_W'(w);  mb = MUL_W'(TICKS_PER_SEC); end
      OP_MUL_KP: begin
        ma = MUL_W'($signed({1'b0, kp_tbl[jsel]}));
        mb = MUL_W'(qd) - MUL_W'(in_r.position);
      end
      OP_MUL_KDL: begin
        ma = MUL_W'($signed({1'b0, kd_tbl[jsel]}));
        mb = MUL_W'($signed({1'b0, diff[DIFF_SPLIT-1:0]}));
      end
      OP_MUL_KDH: begin
        ma = MUL_W'($signed({1'b0, kd_tbl[jsel]}));
        mb = MUL_W'(diff >>> DIFF_SPLIT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  // Divider operands: normalized time or velocity scaling
  always_comb begin
    p_abs     = p[PROD_W-1] ? -p : p;
    div_start = (cmd.op == OP_TDIV_START) || (cmd.op == OP_VDIV_START);
    div_dvd   = (cmd.op == OP_TDIV_START) ? DIV_N'({elapsed, T_W'(0)})
                                          : DIV_N'(p_abs);
  end

  qtpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (duration),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Truncated quotient back to signed, then damping error with clamp
  always_comb begin
    q_signed = vsign ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    dqd      = (DIV_N-7)'(q_signed >>> 8);
    dd_full  = (DIV_N-5)'(dqd) - (DIV_N-5)'(in_r.velocity);
  end

  // Torque scale and saturation
  always_comb begin
    tq = acc >>> TORQUE_SHIFT;
    if (tq[ACC_W-1:TORQUE_W-1] == '0 || tq[ACC_W-1:TORQUE_W-1] == '1) begin
      tq_sat = TORQUE_W'(tq);
    end else begin
      tq_sat = tq[ACC_W-1] ? {1'b1, {(TORQUE_W-1){1'b0}}}
                           : {1'b0, {(TORQUE_W-1){1'b1}}};
    end
  end

  // Configuration and per-joint state
  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= DUR_W'(DUR_RESET);
      elapsed  <= '0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        tgt_tbl[i]   <= '0;
        start_tbl[i] <= '0;
        kp_tbl[i]    <= '0;
        kd_tbl[i]    <= '0;
      end
    end else begin
      if (cfg_write) begin
        duration <= cfg_data;
      end
      if (cmd.op == OP_EXEC) begin
        case (in_r.cmd)
          CMD_LOAD: begin
            if (ok) begin
              tgt_tbl[jsel] <= in_r.target;
              kp_tbl[jsel]  <= in_r.stiffness;
              kd_tbl[jsel]  <= in_r.damping;
            end
          end
          CMD_CAPTURE: begin
            if (ok) begin
              start_tbl[jsel] <= in_r.position;
              elapsed         <= '0;
            end
          end
          CMD_CONTROL: begin
            if (in_r.joint == '0) begin
              elapsed <= e_sum[DUR_W] ? '1 : e_sum[DUR_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT:     in_r <= item;
      OP_FINISH: begin
        s <= S_W'(1 << T_W);
        v <= '0;
      end
      OP_T_STORE:    t  <= div_quo[T_W-1:0];
      OP_ST_T2:      t2 <= T_W'(p >>> T_W);
      OP_ST_T3:      t3 <= T_W'(p >>> T_W);
      OP_ST_T4:      t4 <= T_W'(p >>> T_W);
      OP_ST_T5:      t5 <= T_W'(p >>> T_W);
      OP_POLY: begin
        s <= $signed(s_u);
        v <= $signed(v_u);
      end
      OP_ST_QD:      qd <= QD_W'(PROD_W'(start_sel) + (p >>> T_W));
      OP_ST_W:       w  <= W_W'(p >>> 16);
      OP_VDIV_START: vsign <= p[PROD_W-1];
      OP_ST_DQD: begin
        if (dd_full[DIV_N-6:DIFF_W-1] == '0 || dd_full[DIV_N-6:DIFF_W-1] == '1) begin
          diff <= DIFF_W'(dd_full);
        end else begin
          diff <= dd_full[DIV_N-6] ? {1'b1, {(DIFF_W-1){1'b0}}}
                                   : {1'b0, {(DIFF_W-1){1'b1}}};
        end
      end
      OP_DQD_ZERO:   diff <= -DIFF_W'(in_r.velocity);
      OP_ACC_KP:     acc <= ACC_W'(p);
      OP_ACC_KDL:    acc <= acc + ACC_W'(p);
      OP_ACC_KDH:    acc <= acc + (ACC_W'(p) <<< DIFF_SPLIT);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT || cmd.op == OP_RESULT_ZERO) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      result.torque       <= tq_sat;
      result.joint_out    <= in_r.joint;
      result.torque_valid <= 1'b1;
    end else if (cmd.op == OP_RESULT_ZERO) begin
      result.torque       <= '0;
      result.joint_out    <= in_r.joint;
      result.torque_valid <= 1'b0;
    end
  end

  // Status to the sequencer
  always_comb begin
    status.ctl_ok   = (in_r.cmd == CMD_CONTROL) && ok;
    status.finished = elapsed >= duration;
    status.v_zero   = (v == '0);
    status.div_done = div_done;
    status.out_free = !result_valid || !result_stall;
  end

endmodule

// ===== hw/rtl/qtpd_checker.sv =====
// ----------------------------------------------------------------------------
// qtpd_checker
// Port-level checks of the joint controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "quintic_trajectory_pd_joint_control_top_defines.svh"

module qtpd_checker import qtpd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result beat holds
  `QTPD_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result beat changed while stalled")

  // Non-torque results carry zero torque
  `QTPD_ASSERT_NOW(a_zero_torque, result_valid && !result.torque_valid, result.torque == '0, "torque nonzero on invalid result")

  // Valid torque only for an existing joint
  `QTPD_ASSERT_NOW(a_joint_range, result_valid && result.torque_valid, 32'(result.joint_out) < NUM_JOINTS, "torque for joint out of range")

  // One beat at a time: busy right after an accept
  `QTPD_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "input taken on back-to-back cycles")

endmodule

bind quintic_trajectory_pd_joint_control_top qtpd_checker u_qtpd_checker (.*);
